/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define QLU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define QLU_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* rtl/core/qlu_pkg.sv */
// ----------------------------------------------------------------------------
// qlu_pkg
// Types and constants shared by the quoted literal unescaper.
// ----------------------------------------------------------------------------
package qlu_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OPEN      = 3'd1,
    ERR_CLOSE     = 3'd2,
    ERR_IN_ESC    = 3'd3,
    ERR_BAD_ESC   = 3'd4,
    ERR_BAD_HEX   = 3'd5
  } err_e;

  // Input transfer
  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_t;

  // Output transfer
  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       error_code;
  } out_t;

  // Characters of interest
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // Control bytes produced by escapes
  localparam logic [7:0] BYTE_LF = 8'd10;
  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_HT = 8'd9;
  localparam logic [7:0] BYTE_BS = 8'd8;
  localparam logic [7:0] BYTE_FF = 8'd12;
  localparam logic [7:0] BYTE_VT = 8'd11;

  // Hex digit decode: {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      return {1'b1, t[3:0]};
    end
    if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

/* rtl/core/qlu_decode.sv */
// ----------------------------------------------------------------------------
// qlu_decode
// Literal parser state and per-byte decode; state advances on fire_i.
// ----------------------------------------------------------------------------
module qlu_decode (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  qlu_pkg::in_t item_i,
  output logic         has_res_o,
  output qlu_pkg::out_t res_o
);
  import qlu_pkg::*;

  typedef enum logic [2:0] {
    PH_OPEN = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_SKIP = 3'd5
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] nib_q, nib_d;
  logic [7:0] c;
  logic       fin;
  logic [4:0] hex;

  assign c   = item_i.in_byte;
  assign fin = item_i.final_byte;
  assign hex = hex_digit(c);

  // Next state and result for the current byte
  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    has_res_o = 1'b0;
    res_o     = '{out_byte: 8'd0, kind: KIND_DATA, error_code: ERR_NONE};
    unique case (phase_q)
      PH_BODY: begin
        if (fin) begin
          phase_d   = PH_OPEN;
          has_res_o = 1'b1;
          if (c == CH_DQUOTE) begin
            res_o.kind = KIND_END;
          end else begin
            res_o.kind       = KIND_ERR;
            res_o.error_code = ERR_CLOSE;
          end
        end else if (c == CH_BSLASH) begin
          phase_d = PH_ESC;
        end else begin
          has_res_o      = 1'b1;
          res_o.out_byte = c;
        end
      end
      PH_ESC: begin
        has_res_o = 1'b1;
        if (fin) begin
          phase_d          = PH_OPEN;
          res_o.kind       = KIND_ERR;
          res_o.error_code = ERR_IN_ESC;
        end else begin
          phase_d = PH_BODY;
          case (c)
            CH_SQUOTE, CH_DQUOTE, CH_BSLASH: res_o.out_byte = c;
            CH_N: res_o.out_byte = BYTE_LF;
            CH_R: res_o.out_byte = BYTE_CR;
            CH_T: res_o.out_byte = BYTE_HT;
            CH_B: res_o.out_byte = BYTE_BS;
            CH_F: res_o.out_byte = BYTE_FF;
            CH_V: res_o.out_byte = BYTE_VT;
            CH_X: begin
              phase_d   = PH_HEX1;
              has_res_o = 1'b0;
            end
            default: begin
              phase_d          = PH_SKIP;
              res_o.kind       = KIND_ERR;
              res_o.error_code = ERR_BAD_ESC;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (fin) begin
          phase_d          = PH_OPEN;
          has_res_o        = 1'b1;
          res_o.kind       = KIND_ERR;
          res_o.error_code = ERR_IN_ESC;
        end else if (!hex[4]) begin
          phase_d          = PH_SKIP;
          has_res_o        = 1'b1;
          res_o.kind       = KIND_ERR;
          res_o.error_code = ERR_BAD_HEX;
        end else if (phase_q == PH_HEX1) begin
          phase_d = PH_HEX2;
          nib_d   = hex[3:0];
        end else begin
          phase_d        = PH_BODY;
          has_res_o      = 1'b1;
          res_o.out_byte = {nib_q, hex[3:0]};
        end
      end
      PH_SKIP: begin
        if (fin) phase_d = PH_OPEN;
      end
      default: begin
        // expecting the opening quote; unused codes land here too
        if (c != CH_DQUOTE) begin
          phase_d          = fin ? PH_OPEN : PH_SKIP;
          has_res_o        = 1'b1;
          res_o.kind       = KIND_ERR;
          res_o.error_code = ERR_OPEN;
        end else if (fin) begin
          phase_d          = PH_OPEN;
          has_res_o        = 1'b1;
          res_o.kind       = KIND_ERR;
          res_o.error_code = ERR_CLOSE;
        end else begin
          phase_d = PH_BODY;
        end
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
      nib_q   <= 4'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
    end
  end

  `include "assert_macros.svh"

  `QLU_ASSERT(a_final_reopens, fire_i && fin |=> phase_q == PH_OPEN, "final byte must end literal")
  `QLU_ASSERT_NEVER(a_skip_silent, phase_q == PH_SKIP && has_res_o, "result while skipping")

endmodule

/* rtl/core/quoted_literal_unescaper.sv */
// ----------------------------------------------------------------------------
// quoted_literal_unescaper
// Decodes the bytes of double-quoted literals, one byte per cycle unless stalled.
//
// Every input transfer is one raw byte of a literal, with final_byte marking
// the closing byte. The block accepts one byte each clock cycle unless stalled
// and gives at most one result per byte: a decoded byte, an end marker on a
// correct close, or an error once, after which bytes are dropped up to the
// final byte. A byte lands in the input register at its transfer, is decoded
// by the parser logic and its result is captured in the output register,
// from which it is offered. While a result waits on out_stall_i the input
// register still takes one byte; bytes that give no result keep flowing, and
// a byte with a result waits there until the output register frees. The
// parser state updates with every byte that leaves the input register, which
// sets the rate of one byte per cycle while no result waits on out_stall_i.
// ----------------------------------------------------------------------------
module quoted_literal_unescaper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  qlu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output qlu_pkg::out_t out_data_o
);
  import qlu_pkg::*;

  logic  in_valid_q;
  in_t   in_q;
  logic  out_valid_q;
  out_t  out_q;
  logic  has_res;
  out_t  res;
  logic  out_free;
  logic  adv;
  logic  in_fire;

  // Stage handshake: an item leaves the input register when its result fits or it gives none
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && (out_free || !has_res);
  assign in_stall_o = in_valid_q && !adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  qlu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (adv),
    .item_i    (in_q),
    .has_res_o (has_res),
    .res_o     (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_data_i;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && has_res) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_res) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "assert_macros.svh"

  `QLU_ASSERT(a_data_no_err, out_valid_q && out_q.kind == KIND_DATA |-> out_q.error_code == ERR_NONE, "data result carries error code")
  `QLU_ASSERT(a_err_coded, out_valid_q && out_q.kind == KIND_ERR |-> out_q.error_code != ERR_NONE && out_q.out_byte == 8'd0, "error result malformed")
  `QLU_ASSERT(a_held_item, in_valid_q && !adv |=> in_valid_q && $stable(in_q), "pending byte lost")

endmodule
